// ===== rtl/tilt_compensated_compass_heading_defines.svh =====
// Assertion macros shared by the compass heading RTL.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`ifndef SYNTHESIS
`define TCCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCCH_ASSERT_NOW(lbl, ante, cons, msg)
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tcch_pkg.sv =====
// Types, constants and helpers for the tilt-compensated compass heading block.
`timescale 1ns / 1ps
`default_nettype none
package tcch_pkg;

  localparam int unsigned ATAN_C1      = 5701;
  localparam int unsigned ATAN_C3      = 1645;
  localparam int unsigned ATAN_C5      = 446;
  localparam logic [15:0] HALF_Q15     = 16'h4000;
  localparam logic [15:0] DIV_NORM     = 16'hC000;
  localparam logic [15:0] TRIG_NORM    = 16'hE000;
  localparam logic [15:0] QUARTER_TURN = 16'd9000;
  localparam logic [15:0] HALF_TURN    = 16'd18000;
  localparam logic [15:0] RECIP_100    = 16'd5243;  // 2^19 / 100, rounded up
  localparam logic [8:0]  FULL_CIRCLE  = 9'd360;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } tcch_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SC_INIT, ST_SC_NORM, ST_SC_SQX, ST_SC_SQY, ST_SC_SUM,
    ST_RT_A, ST_RT_B, ST_RT_C, ST_SC_END, ST_ROT1, ST_ROT2,
    ST_AT_START, ST_DV_NORM, ST_DV_STEP, ST_POLY, ST_QUAD,
    ST_DIV_M, ST_DIV_Q, ST_DONE
  } tcch_state_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
  } tcch_sample_t;

  typedef struct packed {
    logic [8:0] heading_deg;
    logic       calibrated;
  } tcch_result_t;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // Most negative word is taken as its neighbour before folding.
  function automatic logic [15:0] clamp16(input logic [15:0] v);
    return (v == 16'h8000) ? 16'h8001 : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tcch_mul.sv =====
// Shared 17x17 signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module tcch_mul
  import tcch_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [15:0]        a,
  input  wire logic [15:0]        b,
  input  wire logic               sgn,
  output      logic signed [33:0] p
);

  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;

  assign a_ext = $signed({sgn & a[15], a});
  assign b_ext = $signed({sgn & b[15], b});

  always_ff @(posedge clk) begin
    p <= a_ext * b_ext;
  end

endmodule
`default_nettype wire

// ===== rtl/tilt_compensated_compass_heading.sv =====
// The time from the start transfer to the done transfer for a tilted sample is set by
// the four root searches (a cosine and a sine one per rotation, 15 trials each) on the
// one shared multiplier; a zero tilt vector skips its searches.
// A new sample is taken only once the last one is done; busy is high throughout.
// Uncalibrated samples (all offsets zero) show done in the cycle after the transfer.
// Reset (synchronous, active high) clears the sequencer and the offsets to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_compensated_compass_heading_defines.svh"
module tilt_compensated_compass_heading
  import tcch_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire tcch_sample_t sample,
  output      logic         busy,
  output      logic         done,
  output      tcch_result_t result,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_idx,
  input  wire logic [15:0]  cfg_data
);

  tcch_state_t state, state_next;

  logic [15:0] offset_x, offset_y, offset_z;
  logic [15:0] bx, by, bz, ax, ay, az;
  logic [15:0] sx, sy, ux, uy, x2, y2, h2, r, d, cv, sv, s, c;
  logic [15:0] acc, fy, t1, t2, ang, cdeg;
  logic [2:0]  k;
  logic        pass, rsel, xlty, xneg, yneg;
  logic [8:0]  heading;
  logic        cal;

  logic [15:0]        mul_a, mul_b;
  logic               mul_sgn;
  logic signed [33:0] mul_p;
  logic [15:0]        q15, rt_try, rt_part, rt_res, fx_sum, at_x, at_y, ang_a, cdeg_v;
  logic               rt_hit;
  logic [7:0]         div_q;

  tcch_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .sgn(mul_sgn), .p(mul_p));

  assign q15     = mul_p[30:15];
  assign div_q   = mul_p[26:19];
  assign rt_try  = r + d;
  assign rt_part = rsel ? y2 : x2;
  assign rt_hit  = (q15 <= rt_part);
  assign rt_res  = rt_hit ? rt_try : r;
  assign fx_sum  = acc + q15;
  assign at_x    = clamp16(fx_sum);
  assign at_y    = clamp16(16'd0 - fy);
  assign ang_a   = xlty ? (QUARTER_TURN - ang) : ang;

  always_comb begin
    case ({xneg, yneg})
      2'b00:   cdeg_v = ang_a;
      2'b01:   cdeg_v = 16'd0 - ang_a;
      2'b10:   cdeg_v = HALF_TURN - ang_a;
      default: cdeg_v = ang_a - HALF_TURN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_a      = 16'd0;
    mul_b      = 16'd0;
    mul_sgn    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ((offset_x | offset_y | offset_z) != 16'd0) ? ST_SC_INIT : ST_DONE;
        end
      end
      ST_SC_INIT: begin
        state_next = ((sx == 16'd0) && (sy == 16'd0)) ? ST_SC_END : ST_SC_NORM;
      end
      ST_SC_NORM: begin
        if (((ux | uy) & TRIG_NORM) != 16'd0) state_next = ST_SC_SQX;
      end
      ST_SC_SQX: begin
        mul_a      = ux;
        mul_b      = ux;
        state_next = ST_SC_SQY;
      end
      ST_SC_SQY: begin
        mul_a      = uy;
        mul_b      = uy;
        state_next = ST_SC_SUM;
      end
      ST_SC_SUM: state_next = ST_RT_A;
      ST_RT_A: begin
        mul_a      = rt_try;
        mul_b      = rt_try;
        state_next = ST_RT_B;
      end
      ST_RT_B: begin
        mul_a      = q15;
        mul_b      = h2;
        state_next = ST_RT_C;
      end
      ST_RT_C: begin
        state_next = ((d == 16'd1) && rsel) ? ST_SC_END : ST_RT_A;
      end
      ST_SC_END: state_next = pass ? ST_ROT2 : ST_ROT1;
      ST_ROT1: begin
        mul_sgn = 1'b1;
        case (k)
          3'd0:    begin mul_a = by; mul_b = c; end
          3'd1:    begin mul_a = bz; mul_b = s; end
          3'd2:    begin mul_a = by; mul_b = s; end
          3'd3:    begin mul_a = bz; mul_b = c; end
          3'd4:    begin mul_a = ay; mul_b = s; end
          3'd5:    begin mul_a = az; mul_b = c; end
          default: begin mul_a = 16'd0; mul_b = 16'd0; end
        endcase
        if (k == 3'd6) state_next = ST_SC_INIT;
      end
      ST_ROT2: begin
        mul_sgn = 1'b1;
        mul_a   = (k == 3'd0) ? bx : bz;
        mul_b   = (k == 3'd0) ? c : s;
        if (k == 3'd2) state_next = ST_AT_START;
      end
      ST_AT_START: state_next = (ux == 16'd0) ? ST_QUAD : ST_DV_NORM;
      ST_DV_NORM: begin
        if (((ux | uy) & DIV_NORM) != 16'd0) state_next = ST_DV_STEP;
      end
      ST_DV_STEP: begin
        if ((uy >> 1) == 16'd0) state_next = ST_POLY;
      end
      ST_POLY: begin
        case (k)
          3'd0:    begin mul_a = 16'(ATAN_C1); mul_b = r; end
          3'd1:    begin mul_a = r; mul_b = r; end
          3'd2:    begin mul_a = q15; mul_b = r; end
          3'd3:    begin mul_a = q15; mul_b = 16'(ATAN_C3); end
          3'd4:    begin mul_a = t2; mul_b = t1; end
          3'd5:    begin mul_a = q15; mul_b = 16'(ATAN_C5); end
          default: begin mul_a = 16'd0; mul_b = 16'd0; end
        endcase
        if (k == 3'd6) state_next = ST_QUAD;
      end
      ST_QUAD: state_next = ST_DIV_M;
      ST_DIV_M: begin
        mul_a      = abs16(cdeg);
        mul_b      = RECIP_100;
        state_next = ST_DIV_Q;
      end
      ST_DIV_Q: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= 16'd0;
      offset_y <= 16'd0;
      offset_z <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          bx   <= sample.mag_x - offset_x;
          by   <= sample.mag_y - offset_y;
          bz   <= sample.mag_z - offset_z;
          ax   <= sample.acc_x;
          ay   <= sample.acc_y;
          az   <= sample.acc_z;
          sx   <= sample.acc_z;
          sy   <= sample.acc_y;
          pass <= 1'b0;
          cal  <= ((offset_x | offset_y | offset_z) != 16'd0);
          heading <= 9'd0;
        end
      end
      ST_SC_INIT: begin
        ux <= abs16(sx);
        uy <= abs16(sy);
        cv <= 16'd0;
        sv <= 16'd0;
      end
      ST_SC_NORM: begin
        if (((ux | uy) & TRIG_NORM) == 16'd0) begin
          ux <= ux << 1;
          uy <= uy << 1;
        end
      end
      ST_SC_SQY: x2 <= q15;
      ST_SC_SUM: begin
        y2   <= q15;
        h2   <= x2 + q15;
        r    <= 16'd0;
        d    <= HALF_Q15;
        rsel <= 1'b0;
      end
      ST_RT_C: begin
        if (d == 16'd1) begin
          // Close this search; start the sine search after the cosine one.
          if (!rsel) begin
            cv   <= rt_res;
            rsel <= 1'b1;
            r    <= 16'd0;
            d    <= HALF_Q15;
          end else begin
            sv <= rt_res;
          end
        end else begin
          r <= rt_res;
          d <= d >> 1;
        end
      end
      ST_SC_END: begin
        c <= (sx[15] && !pass) ? (16'd0 - cv) : cv;
        s <= sy[15] ? (16'd0 - sv) : sv;
        k <= 3'd0;
      end
      ST_ROT1: begin
        k <= k + 3'd1;
        case (k)
          3'd1:    acc <= q15;
          3'd2:    fy  <= acc - q15;
          3'd3:    acc <= q15;
          3'd4:    bz  <= acc + q15;
          3'd5:    acc <= q15;
          3'd6: begin
            sx   <= fx_sum;
            sy   <= 16'd0 - ax;
            pass <= 1'b1;
          end
          default: ;
        endcase
      end
      ST_ROT2: begin
        k <= k + 3'd1;
        if (k == 3'd1) acc <= q15;
        if (k == 3'd2) begin
          xneg <= at_x[15];
          yneg <= at_y[15];
          ux   <= abs16(at_x);
          uy   <= abs16(at_y);
        end
      end
      ST_AT_START: begin
        r <= 16'd0;
        d <= HALF_Q15;
        if (ux == 16'd0) begin
          ang  <= (uy == 16'd0) ? 16'd0 : QUARTER_TURN;
          xlty <= 1'b0;
        end else begin
          xlty <= (ux < uy);
          if (ux > uy) begin
            ux <= uy;
            uy <= ux;
          end
        end
      end
      ST_DV_NORM: begin
        if (((ux | uy) & DIV_NORM) == 16'd0) begin
          ux <= ux << 1;
          uy <= uy << 1;
        end else begin
          uy <= uy >> 1;
        end
      end
      ST_DV_STEP: begin
        if (ux >= uy) begin
          ux <= ux - uy;
          r  <= r | d;
        end
        uy <= uy >> 1;
        d  <= d >> 1;
        k  <= 3'd0;
      end
      ST_POLY: begin
        k <= k + 3'd1;
        case (k)
          3'd1:    ang <= q15;
          3'd2:    t1  <= q15;
          3'd3:    t2  <= q15;
          3'd4:    ang <= ang - q15;
          3'd6:    ang <= ang + q15;
          default: ;
        endcase
      end
      ST_QUAD: cdeg <= cdeg_v;
      ST_DIV_Q: begin
        // Truncate toward zero, then wrap negatives into the circle.
        heading <= (cdeg[15] && (div_q != 8'd0)) ? (FULL_CIRCLE - {1'b0, div_q})
                                                 : {1'b0, div_q};
      end
      default: ;
    endcase
  end

  assign busy               = (state != ST_IDLE);
  assign done               = (state == ST_DONE);
  assign result.heading_deg = heading;
  assign result.calibrated  = cal;

  `TCCH_ASSERT_NOW(a_heading_range, done, heading < FULL_CIRCLE, "heading out of range")
  `TCCH_ASSERT_NOW(a_uncal_zero, done && !cal, heading == 9'd0, "uncalibrated heading not zero")
  `TCCH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `TCCH_ASSERT_NEXT(a_done_single, done, !done && !busy, "done strobe longer than one cycle")

endmodule
`default_nettype wire

// ===== tb/sv/tilt_compensated_compass_heading_tb.sv =====
// Self-checking testbench for the tilt-compensated compass heading block.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_compass_heading_tb;
  import tcch_pkg::*;

  logic         clk;
  logic         rst;
  logic         start;
  tcch_sample_t sample;
  logic         busy;
  logic         done;
  tcch_result_t result;
  logic         cfg_we;
  logic [1:0]   cfg_idx;
  logic [15:0]  cfg_data;

  tilt_compensated_compass_heading DUT (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  tcch_result_t headings_due[$];
  int           fail_count;
  int           sample_count;
  int           heading_count;
  bit           quiet_tail;
  int           hard_iron_x, hard_iron_y, hard_iron_z;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tilt_compensated_compass_heading_tb NOT OK");
    $finish;
  end

  // ---------------- heading predictor ----------------
  function automatic int wrap_word(input int v);
    return int'(shortint'(v));
  endfunction

  function automatic int unsigned mul_uq15(input int unsigned a, input int unsigned b);
    longint unsigned p;
    p = longint'(a & 32'hFFFF) * longint'(b & 32'hFFFF);
    return int'((p >> 15) & 64'hFFFF);
  endfunction

  function automatic int mul_sq15(input int a, input int b);
    int p;
    p = a * b;
    return wrap_word(p >>> 15);
  endfunction

  function automatic int unsigned ratio_q15(input int unsigned num, input int unsigned den);
    int unsigned d, r;
    d = 32'h4000;
    r = 0;
    num &= 32'h7FFF;
    den &= 32'h7FFF;
    if (den == 0) return 0;
    while (((num | den) & 32'hC000) == 0) begin
      num <<= 1;
      den <<= 1;
    end
    den >>= 1;
    do begin
      if (num >= den) begin
        num -= den;
        r |= d;
      end
      den >>= 1;
      d >>= 1;
    end while (den != 0);
    return r & 32'hFFFF;
  endfunction

  function automatic int first_octant_angle(input int y, input int x);
    int unsigned ratio, x2, x3;
    int angle;
    if (x == 0) return (y == 0) ? 0 : 9000;
    ratio = (x > y) ? ratio_q15(y, x) : ratio_q15(x, y);
    angle = int'(mul_uq15(5701, ratio));
    x2 = mul_uq15(ratio, ratio);
    x3 = mul_uq15(x2, ratio);
    angle -= int'(mul_uq15(x3, 1645));
    x3 = mul_uq15(x3, x2);
    angle += int'(mul_uq15(x3, 446));
    return (x < y) ? 9000 - angle : angle;
  endfunction

  function automatic int angle_centideg(input int y, input int x);
    if (x == -32768) x = -32767;
    if (y == -32768) y = -32767;
    if (x >= 0) return (y >= 0) ? first_octant_angle(y, x) : -first_octant_angle(-y, x);
    return (y >= 0) ? 18000 - first_octant_angle(y, -x) : -18000 + first_octant_angle(-y, -x);
  endfunction

  function automatic int root_search(input int unsigned part, input int unsigned total);
    int unsigned r, d, t;
    r = 0;
    d = 32'h4000;
    while (d != 0) begin
      t = mul_uq15(r + d, r + d);
      t = mul_uq15(t, total);
      if (t <= part) r += d;
      d >>= 1;
    end
    return int'(r);
  endfunction

  task automatic tilt_trig(input int x, input int y, output int s, output int c);
    int unsigned ux, uy, x2, y2, h2;
    int cv, sv;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    if (ux == 0 && uy == 0) begin
      s = 0;
      c = 0;
      return;
    end
    while (((ux | uy) & 32'hE000) == 0) begin
      ux <<= 1;
      uy <<= 1;
    end
    x2 = mul_uq15(ux, ux);
    y2 = mul_uq15(uy, uy);
    h2 = (x2 + y2) & 32'hFFFF;
    cv = root_search(x2, h2);
    sv = root_search(y2, h2);
    c = (x < 0) ? -cv : cv;
    s = (y < 0) ? -sv : sv;
  endtask

  task automatic predict_heading(input tcch_sample_t smp, output tcch_result_t res);
    int bx, by, bz, fy, fx, gz, s, c, hd, ax, ay, az;
    bx = wrap_word(int'(smp.mag_x) - hard_iron_x);
    by = wrap_word(int'(smp.mag_y) - hard_iron_y);
    bz = wrap_word(int'(smp.mag_z) - hard_iron_z);
    ax = smp.acc_x;
    ay = smp.acc_y;
    az = smp.acc_z;
    tilt_trig(az, ay, s, c);
    fy = wrap_word(mul_sq15(by, c) - mul_sq15(bz, s));
    bz = wrap_word(mul_sq15(by, s) + mul_sq15(bz, c));
    gz = wrap_word(mul_sq15(ay, s) + mul_sq15(az, c));
    tilt_trig(gz, wrap_word(-ax), s, c);
    if (c < 0) c = -c;
    fx = wrap_word(mul_sq15(bx, c) + mul_sq15(bz, s));
    if (hard_iron_x == 0 && hard_iron_y == 0 && hard_iron_z == 0) begin
      res = '0;
      return;
    end
    hd = angle_centideg(wrap_word(-fy), fx) / 100;
    if (hd < 0) hd += 360;
    res.heading_deg = hd[8:0];
    res.calibrated  = 1'b1;
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    tcch_result_t want;
    if (!rst && done) begin
      heading_count++;
      if (headings_due.size() == 0) begin
        $error("unexpected heading %0d calibrated %0b", result.heading_deg, result.calibrated);
        fail_count++;
      end else begin
        want = headings_due.pop_front();
        if (result.heading_deg !== want.heading_deg) begin
          $error("heading_deg expected %0d actual %0d", want.heading_deg, result.heading_deg);
          fail_count++;
        end
        if (result.calibrated !== want.calibrated) begin
          $error("calibrated expected %0b actual %0b", want.calibrated, result.calibrated);
          fail_count++;
        end
      end
    end
  end

  // ---------------- drivers ----------------
  // Hold start high across back-to-back transfers; drop it only for a gap.
  task automatic send_sample(input tcch_sample_t smp);
    tcch_result_t res;
    int gap;
    if (!start) start <= 1'b1;
    sample <= smp;
    do @(posedge clk); while (busy);
    predict_heading(smp, res);
    headings_due.push_back(res);
    sample_count++;
    gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_block;
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (headings_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_offset(input tcch_reg_t idx, input logic [15:0] val);
    drain_block();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X: hard_iron_x = int'(signed'(val));
      REG_OFFSET_Y: hard_iron_y = int'(signed'(val));
      default:      hard_iron_z = int'(signed'(val));
    endcase
  endtask

  task automatic set_offsets(input logic [15:0] ox, input logic [15:0] oy,
                             input logic [15:0] oz);
    write_offset(REG_OFFSET_X, ox);
    write_offset(REG_OFFSET_Y, oy);
    write_offset(REG_OFFSET_Z, oz);
  endtask

  function automatic tcch_sample_t make_sample(input int mx, input int my, input int mz,
                                               input int ax, input int ay, input int az);
    tcch_sample_t smp;
    smp.mag_x = mx[15:0]; smp.mag_y = my[15:0]; smp.mag_z = mz[15:0];
    smp.acc_x = ax[15:0]; smp.acc_y = ay[15:0]; smp.acc_z = az[15:0];
    return smp;
  endfunction

  // Mostly a plausible gravity vector with random field; the rest is raw noise.
  function automatic tcch_sample_t random_sample();
    tcch_sample_t smp;
    int g;
    smp = tcch_sample_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) < 6) begin
      g = $urandom_range(4000, 20000);
      smp.acc_z = 16'(($urandom_range(0, 7) == 0) ? -g : g);
      smp.acc_x = 16'(int'($urandom_range(0, 2 * g)) - g);
      smp.acc_y = 16'(int'($urandom_range(0, 2 * g)) - g);
      if ($urandom_range(0, 1)) begin
        smp.mag_x = 16'(int'($urandom_range(0, 8000)) - 4000);
        smp.mag_y = 16'(int'($urandom_range(0, 8000)) - 4000);
        smp.mag_z = 16'(int'($urandom_range(0, 8000)) - 4000);
      end
    end
    return smp;
  endfunction

  // ---------------- tests ----------------
  task automatic test_uncalibrated;
    send_sample(make_sample(1000, -2000, 300, 0, 0, 16384));
    send_sample(make_sample(32767, -32768, 0, -32768, 32767, -32768));
    repeat (20) send_sample(random_sample());
  endtask

  task automatic test_corner_samples;
    set_offsets(16'd1, 16'd0, 16'd0);
    send_sample(make_sample(0, 0, 0, 0, 0, 0));              // zero tilt vector
    send_sample(make_sample(1000, 0, 0, 0, 0, 0));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(-32768, 0, 0, 0, 0, 16384));     // full-scale atan operand
    send_sample(make_sample(0, -32768, 0, 0, 0, 16384));
    send_sample(make_sample(5000, 5000, 0, 0, 0, 16384));
    send_sample(make_sample(-5000, 5000, 0, 0, 0, 16384));
    send_sample(make_sample(-5000, -5000, 0, 0, 0, 16384));
    send_sample(make_sample(5000, -5000, 0, 0, 0, 16384));
    send_sample(make_sample(0, 4000, 2000, 16384, 0, 0));    // pitched on end
    send_sample(make_sample(3000, 0, 2000, 0, -16384, 0));   // rolled on side
    send_sample(make_sample(3000, 1000, 2000, 0, 0, -16384));
    send_sample(make_sample(1, -1, 1, 1, -1, 1));
  endtask

  task automatic test_random_offsets(input logic [15:0] ox, input logic [15:0] oy,
                                     input logic [15:0] oz, input int count);
    set_offsets(ox, oy, oz);
    repeat (count) send_sample(random_sample());
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    sample   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_OFFSET_X;
    cfg_data = '0;
    hard_iron_x = 0; hard_iron_y = 0; hard_iron_z = 0;
    fail_count = 0; sample_count = 0; heading_count = 0;
    quiet_tail = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_uncalibrated();
    test_corner_samples();
    test_random_offsets(16'h7FFF, 16'h8000, 16'h7FFF, 100);
    test_random_offsets(16'h8000, 16'h7FFF, 16'h8000, 100);
    test_random_offsets(16'd0, 16'd0, 16'd0, 40);
    test_random_offsets(16'd200, -16'sd150, 16'd75, 200);
    test_random_offsets(16'($urandom), 16'($urandom), 16'($urandom), 150);
    quiet_tail = 1'b1;
    test_random_offsets(-16'sd40, 16'd0, 16'd900, 150);

    drain_block();
    $display("Sent %0d samples, checked %0d headings over seven offset settings,",
             sample_count, heading_count);
    $display("including uncalibrated, full-scale and zero-tilt samples.");
    if (fail_count == 0)
      $display("tilt_compensated_compass_heading_tb OK");
    else
      $display("tilt_compensated_compass_heading_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
